>>> rtl/glsel_pkg.sv
// Shared widths, codes and types of the greedy level-of-detail step selector.
package glsel_pkg;

    localparam int COORD_W   = 16;  // view-space coordinate, signed 8.8
    localparam int RATE_W    = 10;  // frame rate and threshold
    localparam int IDX_OUT_W = 10;  // reported model index
    localparam int LVL_W     = 3;   // stored detail level
    localparam int SQ_W      = 31;  // one squared coordinate, at most 2^30
    localparam int DIST_W    = 32;  // sum of three squares
    localparam int Q_DEPTH   = 4;   // entries between front and back

    localparam logic [RATE_W-1:0] THR_RESET = 10'd32;

    // Command codes of an input transaction
    localparam logic CMD_RESTART = 1'b1;

    // Per-item flags set by the front end
    typedef struct packed {
        logic cmd;       // restart transaction
        logic last;      // final model of the frame
        logic mode;      // 1 = lowering frame
        logic in_range;  // index below the model count
    } t_item_flags;

    // Queue entry apart from the model index
    typedef struct packed {
        t_item_flags             flags;
        logic [DIST_W-1:0]       dist_sq;
    } t_q_meta;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_bk_state;

endpackage

>>> rtl/glsel_if.sv
// Valid/ready channel interfaces for model items and selection results.
interface glsel_in_if import glsel_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [COORD_W-1:0]  view_x;
    logic signed [COORD_W-1:0]  view_y;
    logic signed [COORD_W-1:0]  view_z;
    logic [RATE_W-1:0]          frame_rate;
    logic                       last_model;

    modport source (output valid, cmd, view_x, view_y, view_z, frame_rate, last_model,
                    input ready);
    modport sink   (input valid, cmd, view_x, view_y, view_z, frame_rate, last_model,
                    output ready);
endinterface

interface glsel_out_if import glsel_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IDX_OUT_W-1:0]   chosen_index;
    logic [LVL_W-1:0]       new_level;
    logic                   raised;
    logic                   none_eligible;

    modport source (output valid, chosen_index, new_level, raised, none_eligible,
                    input ready);
    modport sink   (input valid, chosen_index, new_level, raised, none_eligible,
                    output ready);
endinterface

>>> rtl/glsel_front.sv
// Front end: accepts items, numbers models, latches the frame mode, squares coordinates.
module glsel_front import glsel_pkg::*; #(
    parameter int MAX_MODELS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    glsel_in_if.sink                i_in,
    input  logic                    i_cfg_we,
    input  logic [RATE_W-1:0]       i_cfg_wdata,
    input  logic                    i_hold,
    input  logic                    i_full,
    output logic                    o_push,
    output t_q_meta                 o_meta,
    output logic [((MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1)-1:0] o_idx
);

    localparam int IW    = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int CNT_W = $clog2(MAX_MODELS + 1);

    logic [RATE_W-1:0]          r_thr;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           n_cnt;
    logic                       r_mode;
    logic                       n_mode;
    logic                       r_f_v;
    t_item_flags                r_flags;
    t_item_flags                n_flags;
    logic [IW-1:0]              r_idx;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;
    logic [SQ_W-1:0]            r_sq_z;
    logic signed [2*COORD_W-1:0] prod_x;
    logic signed [2*COORD_W-1:0] prod_y;
    logic signed [2*COORD_W-1:0] prod_z;
    logic                       accept;
    logic                       in_range;

    // Handshake: one holding stage, freed when the queue takes it
    assign i_in.ready = !i_hold && (!r_f_v || !i_full);
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = r_f_v && !i_full;

    // Squares of the signed coordinates
    assign prod_x = i_in.view_x * i_in.view_x;
    assign prod_y = i_in.view_y * i_in.view_y;
    assign prod_z = i_in.view_z * i_in.view_z;

    // Model numbering and mode latch on the frame's first item
    always_comb begin
        in_range         = r_cnt < CNT_W'(MAX_MODELS);
        n_mode           = (r_cnt == '0) ? (i_in.frame_rate < r_thr) : r_mode;
        n_flags.cmd      = (i_in.cmd == CMD_RESTART);
        n_flags.last     = i_in.last_model;
        n_flags.mode     = n_mode;
        n_flags.in_range = in_range;
        if (n_flags.cmd || n_flags.last) begin
            n_cnt = '0;
        end else if (in_range) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_cnt  <= '0;
            r_mode <= 1'b0;
            r_f_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept) begin
                r_cnt <= n_cnt;
                if (!n_flags.cmd) begin
                    r_mode <= n_mode;
                end
            end
            if (accept) begin
                r_f_v <= 1'b1;
            end else if (o_push) begin
                r_f_v <= 1'b0;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags <= n_flags;
            r_idx   <= r_cnt[IW-1:0];
            r_sq_x  <= prod_x[SQ_W-1:0];
            r_sq_y  <= prod_y[SQ_W-1:0];
            r_sq_z  <= prod_z[SQ_W-1:0];
        end
    end

    // Squared distance on the way into the queue
    assign o_meta.flags   = r_flags;
    assign o_meta.dist_sq = DIST_W'(r_sq_x) + DIST_W'(r_sq_y) + DIST_W'(r_sq_z);
    assign o_idx          = r_idx;

endmodule

>>> rtl/glsel_fifo.sv
// Small first-in first-out queue between the front end and the back end.
module glsel_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [W-1:0]    i_data,
    input  logic            i_pop,
    output logic [W-1:0]    o_data,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/glsel_back.sv
// Back end: level store, cost compare, recent window, level update and result register.
module glsel_back import glsel_pkg::*; #(
    parameter int MAX_MODELS   = 1024,
    parameter int TOP_LEVEL    = 4,
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_q_meta                 i_head_meta,
    input  logic [((MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1)-1:0] i_head_idx,
    output logic                    o_pop,
    output logic                    o_clearing,
    glsel_out_if.source             o_out
);

    localparam int IW     = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int COST_W = DIST_W + 2 * TOP_LEVEL;

    // Level store and sweep
    logic [LVL_W-1:0]   r_mem [MAX_MODELS];
    logic [LVL_W-1:0]   r_rd_lvl;
    t_bk_state          r_state;
    t_bk_state          n_state;
    logic [IW-1:0]      r_clr_addr;
    logic               clr_done;
    logic               clearing;
    logic               running;

    // Pipeline
    logic               r_b2_v;
    t_q_meta            r_b2_meta;
    logic [IW-1:0]      r_b2_idx;
    logic               r_b3_v;
    t_item_flags        r_b3_flags;
    logic [IW-1:0]      r_b3_idx;
    logic [LVL_W-1:0]   r_b3_lvl;
    logic [COST_W-1:0]  r_b3_cost;
    logic               r_b3_cand;
    logic [COST_W-1:0]  b2_cost;
    logic               b2_lvl_ok;
    logic               hazard;
    logic               adv;

    // Running best and window
    logic [COST_W-1:0]  r_best_cost;
    logic [IW-1:0]      r_best_idx;
    logic [LVL_W-1:0]   r_best_lvl;
    logic               r_best_found;
    logic               r_win_v   [WINDOW_DEPTH];
    logic [IW-1:0]      r_win_idx [WINDOW_DEPTH];
    logic               in_win;
    logic               better;
    logic               take;
    logic [IW-1:0]      nb_idx;
    logic [LVL_W-1:0]   nb_lvl;
    logic               nb_found;
    logic               restart;
    logic               finish;
    logic               wr_we;
    logic [LVL_W-1:0]   wr_lvl;
    logic [IW+IDX_OUT_W-1:0] idx_ext;

    // Result register
    logic               r_o_v;
    logic [IDX_OUT_W-1:0] r_o_idx;
    logic [LVL_W-1:0]   r_o_lvl;
    logic               r_o_raised;
    logic               r_o_none;
    logic               out_free;

    // Sweep state: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: if (clr_done) begin
                n_state = BK_RUN;
            end
            BK_RUN: if (restart) begin
                n_state = BK_CLEAR;
            end
            default: n_state = BK_CLEAR;
        endcase
    end

    // Sweep state: outputs
    always_comb begin
        case (r_state)
            BK_CLEAR: begin
                clearing = 1'b1;
                running  = 1'b0;
            end
            BK_RUN: begin
                clearing = 1'b0;
                running  = 1'b1;
            end
            default: begin
                clearing = 1'b1;
                running  = 1'b0;
            end
        endcase
    end

    assign clr_done   = (r_clr_addr == IW'(MAX_MODELS - 1));
    assign o_clearing = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= clr_done ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    // Pop control: a frame end or restart drains before the next item reads the store
    assign out_free = !r_o_v || o_out.ready;
    assign adv      = !(r_b3_v && r_b3_flags.last && !r_b3_flags.cmd && !out_free);
    assign hazard   = (r_b2_v && (r_b2_meta.flags.last || r_b2_meta.flags.cmd)) ||
                      (r_b3_v && (r_b3_flags.last || r_b3_flags.cmd));
    assign o_pop    = running && !i_empty && adv && !hazard;

    // Level store: sweep write, update write, registered read
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (wr_we) begin
            r_mem[nb_idx] <= wr_lvl;
        end
        if (o_pop) begin
            r_rd_lvl <= r_mem[i_head_idx];
        end
    end

    // Stage 2: eligibility by level and cost
    always_comb begin
        b2_lvl_ok = r_b2_meta.flags.mode ? (r_rd_lvl != '0)
                                         : (r_rd_lvl < LVL_W'(TOP_LEVEL));
        b2_cost   = COST_W'(r_b2_meta.dist_sq) << {r_rd_lvl, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else if (adv) begin
            r_b2_v <= o_pop;
            r_b3_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b2_meta  <= i_head_meta;
            r_b2_idx   <= i_head_idx;
            r_b3_flags <= r_b2_meta.flags;
            r_b3_idx   <= r_b2_idx;
            r_b3_lvl   <= r_rd_lvl;
            r_b3_cost  <= b2_cost;
            r_b3_cand  <= r_b2_meta.flags.in_range && b2_lvl_ok;
        end
    end

    // Stage 3: window match, compare with best, frame end
    always_comb begin
        in_win = 1'b0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            if (r_win_v[k] && (r_win_idx[k] == r_b3_idx)) begin
                in_win = 1'b1;
            end
        end
        better   = r_b3_flags.mode ? (r_b3_cost > r_best_cost) : (r_b3_cost < r_best_cost);
        take     = r_b3_v && !r_b3_flags.cmd && r_b3_cand && !in_win &&
                   (!r_best_found || better);
        nb_idx   = take ? r_b3_idx : r_best_idx;
        nb_lvl   = take ? r_b3_lvl : r_best_lvl;
        nb_found = r_best_found || take;
        restart  = r_b3_v && r_b3_flags.cmd;
        finish   = r_b3_v && r_b3_flags.last && !r_b3_flags.cmd && out_free;
        wr_we    = finish && nb_found;
        wr_lvl   = r_b3_flags.mode ? nb_lvl - 1'b1 : nb_lvl + 1'b1;
        idx_ext  = {{IDX_OUT_W{1'b0}}, nb_idx};
    end

    // Running best of the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
        end else if (adv && r_b3_v) begin
            if (r_b3_flags.cmd || r_b3_flags.last) begin
                r_best_found <= 1'b0;
            end else if (take) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && take) begin
            r_best_cost <= r_b3_cost;
            r_best_idx  <= r_b3_idx;
            r_best_lvl  <= r_b3_lvl;
        end
    end

    // Recent window: newest at the top end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_win_v[k] <= 1'b0;
            end
        end else if (wr_we) begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
                r_win_v[k] <= r_win_v[k + 1];
            end
            r_win_v[WINDOW_DEPTH - 1] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_we) begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
                r_win_idx[k] <= r_win_idx[k + 1];
            end
            r_win_idx[WINDOW_DEPTH - 1] <= nb_idx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (finish) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_idx    <= nb_found ? idx_ext[IDX_OUT_W-1:0] : '0;
            r_o_lvl    <= nb_found ? wr_lvl : '0;
            r_o_raised <= nb_found && !r_b3_flags.mode;
            r_o_none   <= !nb_found;
        end
    end

    assign o_out.valid         = r_o_v;
    assign o_out.chosen_index  = r_o_idx;
    assign o_out.new_level     = r_o_lvl;
    assign o_out.raised        = r_o_raised;
    assign o_out.none_eligible = r_o_none;

    // Checks
    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_pop)
        else $error("item taken from queue during level store sweep");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_we |-> (wr_lvl <= LVL_W'(TOP_LEVEL)))
        else $error("level update leaves the legal range");

    a_window_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_we |=> (r_win_v[WINDOW_DEPTH - 1] &&
                   (r_win_idx[WINDOW_DEPTH - 1] == $past(nb_idx))))
        else $error("chosen model missing from recent window");

    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(clearing) |-> ($past(r_clr_addr) == IW'(MAX_MODELS - 1)))
        else $error("level store sweep ended early");

endmodule

>>> rtl/greedy_lod_step_selector_top.sv
// Top level of the greedy level-of-detail step selector.
//
// i_in carries one transaction per model, in index order, with last_model set on
// the frame's final model; a restart transaction (cmd = 1) sets all levels to 0
// and empties the recent window. o_out delivers one result per frame, on the
// frame's last model: the model raised or lowered and its new level, or
// none_eligible. i_cfg_we/i_cfg_wdata write the rate threshold; the user must
// write it only while idle, which the block does not enforce. Throughput: one
// model per cycle, but the back end pauses after each frame's last model so the
// level update lands before the next frame reads it. The last model reaches
// o_out.valid through the front register into the queue, the store read, the
// cost register and the result register. After reset and after each restart the
// back end clears the level store, one entry a cycle, with i_in.ready low
// meanwhile. When o_out stalls, the back end holds the frame end; the queue of
// four entries and the front register absorb items until i_in.ready drops.
module greedy_lod_step_selector_top import glsel_pkg::*; #(
    parameter int MAX_MODELS   = 1024,
    parameter int TOP_LEVEL    = 4,
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    glsel_in_if.sink            i_in,
    glsel_out_if.source         o_out,
    input  logic                i_cfg_we,
    input  logic [RATE_W-1:0]   i_cfg_wdata
);

    localparam int IW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int QW = $bits(t_q_meta) + IW;

    logic               push;
    logic               pop;
    logic               empty;
    logic               full;
    logic               clearing;
    t_q_meta            f_meta;
    logic [IW-1:0]      f_idx;
    logic [QW-1:0]      q_head;
    t_q_meta            head_meta;
    logic [IW-1:0]      head_idx;

    glsel_front #(
        .MAX_MODELS (MAX_MODELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_hold      (clearing),
        .i_full      (full),
        .o_push      (push),
        .o_meta      (f_meta),
        .o_idx       (f_idx)
    );

    glsel_fifo #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_meta, f_idx}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_empty (empty),
        .o_full  (full)
    );

    assign {head_meta, head_idx} = q_head;

    glsel_back #(
        .MAX_MODELS   (MAX_MODELS),
        .TOP_LEVEL    (TOP_LEVEL),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head_meta (head_meta),
        .i_head_idx  (head_idx),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule
